>>> design/smx_pkg.sv
// shared types, codes and defaults for the stack machine executor
`default_nettype none

package smx_pkg;

    // default sizes
    localparam int STACK_DEPTH_DEF  = 64;
    localparam int MEMORY_WORDS_DEF = 16;

    // opcodes
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_NOR   = 4'd1;
    localparam logic [3:0] OP_IFZ   = 4'd2;
    localparam logic [3:0] OP_HALT  = 4'd3;
    localparam logic [3:0] OP_LOAD  = 4'd4;
    localparam logic [3:0] OP_STORE = 4'd5;
    localparam logic [3:0] OP_POP   = 4'd6;
    localparam logic [3:0] OP_PUSHI = 4'd7;
    localparam logic [3:0] OP_NOOP  = 4'd8;

    // status codes
    localparam logic [2:0] ST_EXEC    = 3'd0;
    localparam logic [2:0] ST_SKIP    = 3'd1;
    localparam logic [2:0] ST_HALTED  = 3'd2;
    localparam logic [2:0] ST_UNDER   = 3'd3;
    localparam logic [2:0] ST_OVER    = 3'd4;
    localparam logic [2:0] ST_BADADDR = 3'd5;

    // what a stack cell does this cycle
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_PUSH,
        SH_POP1,
        SH_POP2
    } shift_op_t;

    // one result word
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] top_value;
        logic [6:0]  stack_depth;
        logic        halted;
        logic        mem_write_valid;
        logic [3:0]  mem_write_addr;
        logic [31:0] mem_write_data;
    } res_t;

endpackage

`default_nettype wire

>>> design/smx_cell.sv
// one stack cell: holds a word and shifts it toward or away from the top
`default_nettype none

module smx_cell (
    input  wire logic               aclk,
    input  wire smx_pkg::shift_op_t op,
    input  wire logic [31:0]        from_up,
    input  wire logic [31:0]        from_dn1,
    input  wire logic [31:0]        from_dn2,
    output logic [31:0]             q,
    output logic [31:0]             d
);

    logic [31:0] value_reg;
    logic [31:0] value_next;

    // select the incoming word
    always_comb begin
        case (op)
            smx_pkg::SH_HOLD: value_next = value_reg;
            smx_pkg::SH_PUSH: value_next = from_up;
            smx_pkg::SH_POP1: value_next = from_dn1;
            smx_pkg::SH_POP2: value_next = from_dn2;
            default:          value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign q = value_reg;
    assign d = value_next;

endmodule

`default_nettype wire

>>> design/smx_dmem.sv
// data memory with registered read and valid bits for cleared-at-reset words
`default_nettype none

module smx_dmem #(
    parameter int WORDS = smx_pkg::MEMORY_WORDS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(WORDS)-1:0]   wr_addr,
    input  wire logic [31:0]                wr_data,
    input  wire logic [31:0]                rd_addr,
    output logic [31:0]                     rd_data
);

    localparam int AW = $clog2(WORDS);

    logic [31:0]      mem [0:WORDS-1];
    logic [WORDS-1:0] valid_reg;
    logic [31:0]      rd_word_reg;
    logic [31:0]      fwd_data_reg;
    logic             rd_valid_reg;
    logic             fwd_hit_reg;
    logic [AW-1:0]    rd_idx;

    // out-of-range reads are never used, steer them to word zero
    assign rd_idx = (rd_addr < 32'(WORDS)) ? rd_addr[AW-1:0] : '0;

    // storage and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg  <= mem[rd_idx];
        fwd_data_reg <= wr_data;
    end

    // valid bits and read bypass flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_idx];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_idx);
        end
    end

    // a word never written reads as zero
    assign rd_data = fwd_hit_reg  ? fwd_data_reg :
                     rd_valid_reg ? rd_word_reg  : 32'd0;

endmodule

`default_nettype wire

>>> design/smx_obuf.sv
// result register with a skid stage
`default_nettype none

module smx_obuf (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire smx_pkg::res_t in_word,
    output logic               out_valid,
    input  wire logic          out_ready,
    output smx_pkg::res_t      out_word
);

    logic          out_valid_reg;
    logic          out_valid_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    smx_pkg::res_t out_word_reg;
    smx_pkg::res_t out_word_next;
    smx_pkg::res_t skid_word_reg;
    smx_pkg::res_t skid_word_next;
    logic          push;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;

    // move words from input or skid into the output register, or park the input in the skid while stalled
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_word_next  = in_word;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_word_next  = in_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

>>> design/stack_machine_executor.sv
// stack machine executor top level
`default_nettype none

// Executes one stack-machine instruction per word and returns one result word per
// instruction. Throughput is one instruction per clock while s_ready is high: the
// operand stack is a row of STACK_DEPTH cells with the top in cell 0, and every push,
// pop or double pop is a shift of the whole row, so an instruction only ever works on
// cells 0 and 1. The data memory is read ahead at the address that the next top of
// stack will hold, so LOAD also needs no wait on the memory read. Each result is
// registered in the output buffer; a two-word output buffer keeps s_ready high while
// one finished result waits on m_ready. Data memory reads as zero after reset without
// any clearing pass. Underflow, overflow and bad addresses are reported in m_status
// and leave the state unchanged.
module stack_machine_executor #(
    parameter int STACK_DEPTH  = smx_pkg::STACK_DEPTH_DEF,
    parameter int MEMORY_WORDS = smx_pkg::MEMORY_WORDS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [3:0]   s_kind,
    input  wire logic [31:0]  s_operand,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [2:0]        m_status,
    output logic [31:0]       m_top_value,
    output logic [6:0]        m_stack_depth,
    output logic              m_halted,
    output logic              m_mem_write_valid,
    output logic [3:0]        m_mem_write_addr,
    output logic [31:0]       m_mem_write_data
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(MEMORY_WORDS);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [30:0]         skip_reg;
    logic [30:0]         skip_next;
    logic                halt_reg;
    logic                halt_next;

    logic [31:0]         cell_q [0:STACK_DEPTH-1];
    logic [31:0]         cell_d [0:STACK_DEPTH-1];
    smx_pkg::shift_op_t  op_top;
    smx_pkg::shift_op_t  op_rest;
    smx_pkg::shift_op_t  op_top_eff;
    smx_pkg::shift_op_t  op_rest_eff;
    logic [31:0]         new_top;
    logic [31:0]         top_word;
    logic [31:0]         second_word;
    logic [31:0]         mem_rd_data;
    logic                addr_ok;

    logic [2:0]          status;
    logic                wr_en;
    logic                accept;
    logic [CW+6:0]       depth_wide;
    smx_pkg::res_t       res;
    smx_pkg::res_t       res_out;

    assign accept      = s_valid && s_ready;
    assign top_word    = cell_q[0];
    assign second_word = cell_q[1];
    assign addr_ok     = top_word < 32'(MEMORY_WORDS);

    // instruction decode and state update
    always_comb begin
        status     = smx_pkg::ST_EXEC;
        op_top     = smx_pkg::SH_HOLD;
        op_rest    = smx_pkg::SH_HOLD;
        new_top    = s_operand;
        count_next = count_reg;
        skip_next  = skip_reg;
        halt_next  = halt_reg;
        wr_en      = 1'b0;
        if (halt_reg) begin
            status = smx_pkg::ST_HALTED;
        end else if (skip_reg != 31'd0) begin
            status    = smx_pkg::ST_SKIP;
            skip_next = skip_reg - 31'd1;
        end else begin
            case (s_kind)
                smx_pkg::OP_ADD, smx_pkg::OP_NOR: begin
                    if (count_reg < CW'(2)) begin
                        status = smx_pkg::ST_UNDER;
                    end else begin
                        new_top    = (s_kind == smx_pkg::OP_ADD) ?
                                     (top_word + second_word) :
                                     ~(top_word | second_word);
                        op_top     = smx_pkg::SH_PUSH;
                        op_rest    = smx_pkg::SH_POP1;
                        count_next = count_reg - CW'(1);
                    end
                end
                smx_pkg::OP_IFZ: begin
                    if (count_reg == '0) begin
                        status = smx_pkg::ST_UNDER;
                    end else begin
                        op_top     = smx_pkg::SH_POP1;
                        op_rest    = smx_pkg::SH_POP1;
                        count_next = count_reg - CW'(1);
                        if (top_word == 32'd0 && !s_operand[31]) begin
                            skip_next = s_operand[30:0];
                        end
                    end
                end
                smx_pkg::OP_HALT: begin
                    halt_next = 1'b1;
                end
                smx_pkg::OP_LOAD: begin
                    if (count_reg == '0) begin
                        status = smx_pkg::ST_UNDER;
                    end else if (!addr_ok) begin
                        status = smx_pkg::ST_BADADDR;
                    end else begin
                        new_top = mem_rd_data;
                        op_top  = smx_pkg::SH_PUSH;
                    end
                end
                smx_pkg::OP_STORE: begin
                    if (count_reg < CW'(2)) begin
                        status = smx_pkg::ST_UNDER;
                    end else if (!addr_ok) begin
                        status = smx_pkg::ST_BADADDR;
                    end else begin
                        op_top     = smx_pkg::SH_POP2;
                        op_rest    = smx_pkg::SH_POP2;
                        count_next = count_reg - CW'(2);
                        wr_en      = 1'b1;
                    end
                end
                smx_pkg::OP_POP: begin
                    if (count_reg == '0) begin
                        status = smx_pkg::ST_UNDER;
                    end else begin
                        op_top     = smx_pkg::SH_POP1;
                        op_rest    = smx_pkg::SH_POP1;
                        count_next = count_reg - CW'(1);
                    end
                end
                smx_pkg::OP_PUSHI: begin
                    if (count_reg == CW'(STACK_DEPTH)) begin
                        status = smx_pkg::ST_OVER;
                    end else begin
                        op_top     = smx_pkg::SH_PUSH;
                        op_rest    = smx_pkg::SH_PUSH;
                        count_next = count_reg + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // the row only moves when a word is taken
    assign op_top_eff  = accept ? op_top  : smx_pkg::SH_HOLD;
    assign op_rest_eff = accept ? op_rest : smx_pkg::SH_HOLD;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            skip_reg  <= '0;
            halt_reg  <= 1'b0;
        end else if (accept) begin
            count_reg <= count_next;
            skip_reg  <= skip_next;
            halt_reg  <= halt_next;
        end
    end

    // operand stack as a row of cells, top in cell 0
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [31:0] up_w;
        logic [31:0] dn1_w;
        logic [31:0] dn2_w;

        if (i == 0) begin : g_top
            assign up_w = new_top;
        end else begin : g_mid
            assign up_w = cell_q[i-1];
        end
        if (i + 1 < STACK_DEPTH) begin : g_dn1
            assign dn1_w = cell_q[i+1];
        end else begin : g_dn1_end
            assign dn1_w = 32'd0;
        end
        if (i + 2 < STACK_DEPTH) begin : g_dn2
            assign dn2_w = cell_q[i+2];
        end else begin : g_dn2_end
            assign dn2_w = 32'd0;
        end

        smx_cell u_cell (
            .aclk     (aclk),
            .op       ((i == 0) ? op_top_eff : op_rest_eff),
            .from_up  (up_w),
            .from_dn1 (dn1_w),
            .from_dn2 (dn2_w),
            .q        (cell_q[i]),
            .d        (cell_d[i])
        );
    end

    // data memory, read ahead at the next top of stack
    smx_dmem #(
        .WORDS (MEMORY_WORDS)
    ) u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept && wr_en),
        .wr_addr (top_word[AW-1:0]),
        .wr_data (second_word),
        .rd_addr (cell_d[0]),
        .rd_data (mem_rd_data)
    );

    // result word
    assign depth_wide = {7'd0, count_next};

    always_comb begin
        res.status          = status;
        res.top_value       = (count_next != '0) ? cell_d[0] : 32'd0;
        res.stack_depth     = depth_wide[6:0];
        res.halted          = halt_next;
        res.mem_write_valid = wr_en;
        res.mem_write_addr  = wr_en ? top_word[3:0] : 4'd0;
        res.mem_write_data  = wr_en ? second_word : 32'd0;
    end

    smx_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (res_out)
    );

    assign m_status          = res_out.status;
    assign m_top_value       = res_out.top_value;
    assign m_stack_depth     = res_out.stack_depth;
    assign m_halted          = res_out.halted;
    assign m_mem_write_valid = res_out.mem_write_valid;
    assign m_mem_write_addr  = res_out.mem_write_addr;
    assign m_mem_write_data  = res_out.mem_write_data;

endmodule

`default_nettype wire

>>> design/smx_checker.sv
// port-level checks for the stack machine executor, bound to the top level
`default_nettype none

module smx_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [31:0] m_top_value,
    input wire logic [6:0]  m_stack_depth,
    input wire logic        m_halted,
    input wire logic        m_mem_write_valid,
    input wire logic [3:0]  m_mem_write_addr,
    input wire logic [31:0] m_mem_write_data
);

    logic seen_halt_reg;

    // remember that a halted result has been delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_halt_reg <= 1'b0;
        end else if (m_valid && m_ready && m_halted) begin
            seen_halt_reg <= 1'b1;
        end
    end

    // after halt every word is ignored and still reports halted
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_halt_reg |-> m_halted && (m_status == smx_pkg::ST_HALTED))
        else $error("result after halt not reported as ignored");

    // a memory write only comes from an executed store
    a_write_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mem_write_valid |-> (m_status == smx_pkg::ST_EXEC) && !m_halted)
        else $error("memory write on a word that did not execute");

    // empty stack shows zero on top
    a_empty_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_stack_depth == 7'd0) |-> (m_top_value == 32'd0))
        else $error("nonzero top value with empty stack");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_top_value)
            && $stable(m_stack_depth) && $stable(m_halted)
            && $stable(m_mem_write_valid) && $stable(m_mem_write_addr)
            && $stable(m_mem_write_data))
        else $error("result changed while stalled");

endmodule

bind stack_machine_executor smx_checker u_smx_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the stack machine executor
`default_nettype none

module tb_top;

    localparam int STK_DEPTH  = smx_pkg::STACK_DEPTH_DEF;
    localparam int MEM_WORDS  = smx_pkg::MEMORY_WORDS_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 250;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] opnd;
    } instr_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [3:0]  s_kind    = '0;
    logic [31:0] s_operand = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_top_value;
    logic [6:0]  m_stack_depth;
    logic        m_halted;
    logic        m_mem_write_valid;
    logic [3:0]  m_mem_write_addr;
    logic [31:0] m_mem_write_data;

    stack_machine_executor i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_operand         (s_operand),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_top_value       (m_top_value),
        .m_stack_depth     (m_stack_depth),
        .m_halted          (m_halted),
        .m_mem_write_valid (m_mem_write_valid),
        .m_mem_write_addr  (m_mem_write_addr),
        .m_mem_write_data  (m_mem_write_data)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow machine state
    logic [31:0] shadow_stack [STK_DEPTH];
    logic [31:0] shadow_mem [MEM_WORDS] = '{default: '0};
    int          shadow_depth = 0;
    logic [30:0] shadow_skip  = '0;
    logic        shadow_halt  = 1'b0;

    instr_t        program_q[$];
    smx_pkg::res_t step_results_q[$];
    int            n_program  = 0;
    int            n_accepted = 0;
    int            n_results  = 0;
    int            n_err      = 0;
    logic          s_took     = 1'b0;

    // run one instruction on the shadow state and return the result word it gives
    function automatic smx_pkg::res_t execute_instr(input logic [3:0] kind,
                                                    input logic [31:0] opnd);
        smx_pkg::res_t r;
        logic [31:0]   a;
        logic [31:0]   b;
        r = '0;
        r.status = smx_pkg::ST_EXEC;
        if (shadow_halt) begin
            r.status = smx_pkg::ST_HALTED;
        end else if (shadow_skip != '0) begin
            r.status = smx_pkg::ST_SKIP;
            shadow_skip = shadow_skip - 31'd1;
        end else begin
            case (kind)
                smx_pkg::OP_ADD, smx_pkg::OP_NOR: begin
                    if (shadow_depth < 2) begin
                        r.status = smx_pkg::ST_UNDER;
                    end else begin
                        a = shadow_stack[shadow_depth-1];
                        b = shadow_stack[shadow_depth-2];
                        shadow_depth--;
                        shadow_stack[shadow_depth-1] =
                            (kind == smx_pkg::OP_ADD) ? a + b : ~(a | b);
                    end
                end
                smx_pkg::OP_IFZ: begin
                    if (shadow_depth < 1) begin
                        r.status = smx_pkg::ST_UNDER;
                    end else begin
                        a = shadow_stack[shadow_depth-1];
                        shadow_depth--;
                        // a negative count skips nothing
                        if (a == '0) shadow_skip = opnd[31] ? '0 : opnd[30:0];
                    end
                end
                smx_pkg::OP_HALT: begin
                    shadow_halt = 1'b1;
                end
                smx_pkg::OP_LOAD: begin
                    if (shadow_depth < 1) begin
                        r.status = smx_pkg::ST_UNDER;
                    end else begin
                        a = shadow_stack[shadow_depth-1];
                        if (a >= 32'(MEM_WORDS)) r.status = smx_pkg::ST_BADADDR;
                        else shadow_stack[shadow_depth-1] = shadow_mem[a[3:0]];
                    end
                end
                smx_pkg::OP_STORE: begin
                    // underflow wins over a bad address
                    if (shadow_depth < 2) begin
                        r.status = smx_pkg::ST_UNDER;
                    end else begin
                        a = shadow_stack[shadow_depth-1];
                        b = shadow_stack[shadow_depth-2];
                        if (a >= 32'(MEM_WORDS)) begin
                            r.status = smx_pkg::ST_BADADDR;
                        end else begin
                            shadow_mem[a[3:0]] = b;
                            shadow_depth -= 2;
                            r.mem_write_valid = 1'b1;
                            r.mem_write_addr  = a[3:0];
                            r.mem_write_data  = b;
                        end
                    end
                end
                smx_pkg::OP_POP: begin
                    if (shadow_depth < 1) r.status = smx_pkg::ST_UNDER;
                    else shadow_depth--;
                end
                smx_pkg::OP_PUSHI: begin
                    if (shadow_depth >= STK_DEPTH) begin
                        r.status = smx_pkg::ST_OVER;
                    end else begin
                        shadow_stack[shadow_depth] = opnd;
                        shadow_depth++;
                    end
                end
                default: ;
            endcase
        end
        r.top_value   = (shadow_depth != 0) ? shadow_stack[shadow_depth-1] : '0;
        r.stack_depth = 7'(shadow_depth);
        r.halted      = shadow_halt;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // operand value with the extremes showing up often
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 19))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_instr(input logic [3:0] kind, input logic [31:0] opnd);
        instr_t it;
        it.kind = kind;
        it.opnd = opnd;
        program_q.push_back(it);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            n_err++;
        end
    endtask

    // random instruction sequences, mostly well formed
    task automatic add_random_seq();
        int          r;
        logic [31:0] bad;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            add_instr(smx_pkg::OP_PUSHI, rand_word());
        end else if (r < 35) begin
            add_instr(smx_pkg::OP_PUSHI, 32'($urandom_range(0, MEM_WORDS - 1)));
            add_instr(smx_pkg::OP_LOAD, $urandom());
        end else if (r < 50) begin
            add_instr(smx_pkg::OP_PUSHI, rand_word());
            add_instr(smx_pkg::OP_PUSHI, 32'($urandom_range(0, MEM_WORDS - 1)));
            add_instr(smx_pkg::OP_STORE, $urandom());
        end else if (r < 64) begin
            add_instr($urandom_range(0, 1) ? smx_pkg::OP_ADD : smx_pkg::OP_NOR, $urandom());
        end else if (r < 76) begin
            add_instr(smx_pkg::OP_POP, $urandom());
        end else if (r < 84) begin
            add_instr(smx_pkg::OP_PUSHI, $urandom_range(0, 2) ? 32'h0 : rand_word());
            add_instr(smx_pkg::OP_IFZ, $urandom_range(0, 4) ? 32'($urandom_range(0, 4))
                                                            : ($urandom() | 32'h8000_0000));
        end else if (r < 89) begin
            bad = $urandom_range(0, 1) ? 32'($urandom_range(MEM_WORDS, MEM_WORDS + 300))
                                       : ($urandom() | 32'h8000_0000);
            add_instr(smx_pkg::OP_PUSHI, bad);
            add_instr($urandom_range(0, 1) ? smx_pkg::OP_LOAD : smx_pkg::OP_STORE,
                      $urandom());
        end else if (r < 95) begin
            add_instr(4'($urandom_range(8, 15)), $urandom());
        end else begin
            add_instr(smx_pkg::OP_IFZ, 32'($urandom_range(0, 3)));
        end
    endtask

    // stimulus and end of run
    initial begin
        int i;
        // underflow on an empty stack for every popping opcode
        add_instr(smx_pkg::OP_ADD, 32'h0);
        add_instr(smx_pkg::OP_NOR, 32'h0);
        add_instr(smx_pkg::OP_POP, 32'h0);
        add_instr(smx_pkg::OP_IFZ, 32'h0);
        add_instr(smx_pkg::OP_LOAD, 32'h0);
        add_instr(smx_pkg::OP_STORE, 32'h0);
        // nop and unused opcodes
        add_instr(smx_pkg::OP_NOOP, 32'hFFFF_FFFF);
        add_instr(4'd9, 32'h0);
        add_instr(4'd15, 32'h5555_AAAA);
        // add wraps around, then a nor
        add_instr(smx_pkg::OP_PUSHI, 32'h7FFF_FFFF);
        add_instr(smx_pkg::OP_PUSHI, 32'h0000_0001);
        add_instr(smx_pkg::OP_ADD, 32'h0);
        add_instr(smx_pkg::OP_PUSHI, 32'h0F0F_0F0F);
        add_instr(smx_pkg::OP_NOR, 32'h0);
        // store and load at the top address
        add_instr(smx_pkg::OP_PUSHI, 32'(MEM_WORDS - 1));
        add_instr(smx_pkg::OP_STORE, 32'h0);
        add_instr(smx_pkg::OP_PUSHI, 32'(MEM_WORDS - 1));
        add_instr(smx_pkg::OP_LOAD, 32'h0);
        // address just past the end, and a negative one
        add_instr(smx_pkg::OP_PUSHI, 32'(MEM_WORDS));
        add_instr(smx_pkg::OP_LOAD, 32'h0);
        add_instr(smx_pkg::OP_PUSHI, 32'h8000_0000);
        add_instr(smx_pkg::OP_STORE, 32'h0);
        // taken skip that swallows a halt, then a negative skip count
        add_instr(smx_pkg::OP_PUSHI, 32'h0);
        add_instr(smx_pkg::OP_IFZ, 32'd2);
        add_instr(smx_pkg::OP_HALT, 32'h0);
        add_instr(smx_pkg::OP_PUSHI, 32'h1234_5678);
        add_instr(smx_pkg::OP_PUSHI, 32'h0);
        add_instr(smx_pkg::OP_IFZ, 32'hFFFF_FFFB);

        // random body with a stack fill and a stack drain in between
        for (i = 0; i < 70; i++) add_random_seq();
        for (i = 0; i < STK_DEPTH + 6; i++) add_instr(smx_pkg::OP_PUSHI, rand_word());
        for (i = 0; i < 40; i++) add_random_seq();
        for (i = 0; i < STK_DEPTH + 6; i++) add_instr(smx_pkg::OP_POP, $urandom());
        for (i = 0; i < 40; i++) add_random_seq();

        // longer skip, then a skipped halt, then a real one
        add_instr(smx_pkg::OP_PUSHI, 32'h0);
        add_instr(smx_pkg::OP_IFZ, 32'd37);
        for (i = 0; i < 37; i++) add_instr(4'($urandom_range(0, 15)), rand_word());
        add_instr(smx_pkg::OP_PUSHI, 32'h0);
        add_instr(smx_pkg::OP_IFZ, 32'd2);
        add_instr(smx_pkg::OP_HALT, 32'h0);
        add_instr(smx_pkg::OP_ADD, 32'h0);
        add_instr(smx_pkg::OP_HALT, 32'h0);
        for (i = 0; i < 8; i++) add_instr(4'($urandom_range(0, 15)), rand_word());
        n_program = program_q.size();

        // reset once
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_program) @(posedge aclk);
        while (step_results_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // input driver: new word at the falling edge once the last one was taken
    int s_gap  = 0;
    int s_calm = 0;
    always @(negedge aclk) begin
        instr_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_took) begin
            s_valid <= 1'b1;
        end else if (s_gap > 0) begin
            s_valid <= 1'b0;
            s_gap--;
        end else if (program_q.size() != 0) begin
            it = program_q.pop_front();
            s_valid   <= 1'b1;
            s_kind    <= it.kind;
            s_operand <= it.opnd;
            if (s_calm > 0) begin
                s_calm--;
            end else if ($urandom_range(0, 39) == 0) begin
                s_calm = $urandom_range(20, 60);
            end else begin
                s_gap = pick_gap();
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // accepted instruction: predict its result word
    always @(posedge aclk) begin
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            step_results_q.push_back(execute_instr(s_kind, s_operand));
            n_accepted++;
        end
    end

    // result side back-pressure, with one long hold-off to fill the block
    int  m_gap     = 0;
    int  m_calm    = 0;
    int  hold_left = 0;
    bit  held_once = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!held_once && n_results >= 120) begin
            m_ready <= 1'b0;
            held_once = 1'b1;
            hold_left = HOLD_LEN;
        end else if (m_gap > 0) begin
            m_ready <= 1'b0;
            m_gap--;
        end else begin
            m_ready <= 1'b1;
            if (m_calm > 0) begin
                m_calm--;
            end else if ($urandom_range(0, 39) == 0) begin
                m_calm = $urandom_range(20, 60);
            end else begin
                m_gap = pick_gap();
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        smx_pkg::res_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (step_results_q.size() == 0) begin
                $error("result word with no instruction pending");
                n_err++;
            end else begin
                exp_r = step_results_q.pop_front();
                check_field("status", 32'(exp_r.status), 32'(m_status));
                check_field("top_value", exp_r.top_value, m_top_value);
                check_field("stack_depth", 32'(exp_r.stack_depth), 32'(m_stack_depth));
                check_field("halted", 32'(exp_r.halted), 32'(m_halted));
                check_field("mem_write_valid", 32'(exp_r.mem_write_valid),
                            32'(m_mem_write_valid));
                check_field("mem_write_addr", 32'(exp_r.mem_write_addr),
                            32'(m_mem_write_addr));
                check_field("mem_write_data", exp_r.mem_write_data, m_mem_write_data);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
